@@ src/low_precision_float_converter_macros.svh @@
// ----------------------------------------------------------------------------
// Low precision float converter assertion macros
// Shared helpers for the concurrent assertions of the converter.
// ----------------------------------------------------------------------------
`ifndef LOW_PRECISION_FLOAT_CONVERTER_MACROS_SVH
`define LOW_PRECISION_FLOAT_CONVERTER_MACROS_SVH

// Checked only while out of reset.
`define LPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define LPFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Low precision float converter package
// Format codes and float32 constants shared by the converter modules.
// ----------------------------------------------------------------------------
package lpfc_pkg;

  typedef logic [1:0] fmt_t;

  localparam fmt_t FMT_E4M3 = 2'd0;
  localparam fmt_t FMT_E5M2 = 2'd1;
  localparam fmt_t FMT_E8M0 = 2'd2;
  localparam fmt_t FMT_E2M1 = 2'd3;

  localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] F32_PINF  = 32'h7F80_0000;
  localparam logic [31:0] E8M0_MIN  = 32'h0040_0000;

endpackage

@@ src/lpfc_decode.sv @@
// ----------------------------------------------------------------------------
// Low precision float converter decoder
// Expands one small-format code into its exact float32 bit pattern.
// ----------------------------------------------------------------------------
module lpfc_decode (
  input  lpfc_pkg::fmt_t fmt,
  input  logic [7:0]     code,
  output logic [31:0]    value
);
  import lpfc_pkg::*;

  logic       sgn;
  logic [4:0] e;
  logic [2:0] mf;
  logic [7:0] exb;
  logic       is_nan;
  logic       is_inf;
  logic [7:0] exp32;
  logic [22:0] man32;
  logic       is_zero;

  always_comb begin
    sgn    = code[7];
    e      = 5'd0;
    mf     = 3'd0;
    exb    = 8'd120;
    is_nan = 1'b0;
    is_inf = 1'b0;
    case (fmt)
      FMT_E4M3: begin
        e      = {1'b0, code[6:3]};
        mf     = code[2:0];
        exb    = 8'd120;
        is_nan = (code[6:0] == 7'h7f);
      end
      FMT_E5M2: begin
        e      = code[6:2];
        mf     = {code[1:0], 1'b0};
        exb    = 8'd112;
        is_nan = (code[6:2] == 5'h1f) && (code[1:0] != 2'd0);
        is_inf = (code[6:2] == 5'h1f) && (code[1:0] == 2'd0);
      end
      default: begin
        sgn = code[3];
        e   = {3'b0, code[2:1]};
        mf  = {code[0], 2'b0};
        exb = 8'd126;
      end
    endcase

    is_zero = 1'b0;
    if (e != 5'd0) begin
      exp32 = exb + {3'b0, e};
      man32 = {mf, 20'd0};
    end else if (mf[2]) begin
      exp32 = exb;
      man32 = {mf[1:0], 21'd0};
    end else if (mf[1]) begin
      exp32 = exb - 8'd1;
      man32 = {mf[0], 22'd0};
    end else if (mf[0]) begin
      exp32 = exb - 8'd2;
      man32 = 23'd0;
    end else begin
      exp32   = 8'd0;
      man32   = 23'd0;
      is_zero = 1'b1;
    end

    if (fmt == FMT_E8M0) begin
      if (code == 8'hff) begin
        value = F32_QNAN;
      end else if (code == 8'h00) begin
        value = E8M0_MIN;
      end else begin
        value = {1'b0, code, 23'd0};
      end
    end else if (is_nan) begin
      value = F32_QNAN;
    end else if (is_inf) begin
      value = {sgn, F32_PINF[30:0]};
    end else if (is_zero) begin
      value = {sgn, 31'd0};
    end else begin
      value = {sgn, exp32, man32};
    end
  end

endmodule

@@ src/low_precision_float_converter.sv @@
// ----------------------------------------------------------------------------
// Low precision float converter
// Converts between float32 and E4M3, E5M2, E8M0 or E2M1 in a three-stage
// pipeline: classify and align, shift with guard and sticky, round and pack.
// ----------------------------------------------------------------------------
// Channel  Direction  Transaction content
// in_      slave      tuser: mode; tdata: code_in [7:0], value_in [39:8]
// out_     master     tdata: code_out [7:0], value_out [39:8]
// cfg_     write      wr_data: format
//
// An accepted transaction moves from the stage 1 register through stage 2 into the output register.
// One transaction is accepted per cycle while in_tready is high; the three stage registers set that.
// A stall on the output holds each stage that is full; empty stages still fill.
// Reset clears the stage valid bits and sets the format to E4M3.
// ----------------------------------------------------------------------------
module low_precision_float_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // code_in [7:0], value_in [39:8]
  input  logic                 in_tuser,   // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // code_out [7:0], value_out [39:8]
  input  logic                 cfg_wr_en,
  input  lpfc_pkg::fmt_t       cfg_wr_data
);
  import lpfc_pkg::*;

  fmt_t        fmt_r;
  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;

  logic        mode1_r, spec1_r;
  fmt_t        fmt1_r;
  logic [7:0]  code1_r, sb1_r;
  logic [23:0] sig1_r;
  logic [4:0]  sh1_r, ef1_r;
  logic [31:0] dec1_r;

  logic        mode2_r, spec2_r, up2_r;
  fmt_t        fmt2_r;
  logic [7:0]  code2_r, sb2_r;
  logic [3:0]  n2_r;
  logic [4:0]  ef2_r;
  logic [31:0] dec2_r;

  logic [7:0]  code3_r;
  logic [31:0] value3_r;

  logic [7:0]  code_in;
  logic [31:0] value_in;
  logic [31:0] dec_value;

  logic [30:0] a;
  logic [7:0]  ex;
  logic [31:0] max_bits;
  logic [7:0]  emin_b, max_c, nan_c, sb_c;
  logic [1:0]  mb;
  logic        spec1_nxt;
  logic [7:0]  code1_nxt, d, efw, e8;
  logic [8:0]  shw;
  logic [4:0]  sh1_nxt;

  logic [31:0] sig32, shifted, below;
  logic        guard, sticky;

  logic [7:0]  base, code3_nxt;

  assign code_in  = in_tdata[7:0];
  assign value_in = in_tdata[39:8];

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  lpfc_decode u_decode (
    .fmt   (fmt_r),
    .code  (code_in),
    .value (dec_value)
  );

  always_comb begin
    a  = value_in[30:0];
    ex = value_in[30:23];
    case (fmt_r)
      FMT_E4M3: begin
        max_bits = 32'h43E0_0000; emin_b = 8'd121; mb = 2'd3;
        sb_c = 8'h80; max_c = 8'h7e; nan_c = 8'h7f;
      end
      FMT_E5M2: begin
        max_bits = 32'h4760_0000; emin_b = 8'd113; mb = 2'd2;
        sb_c = 8'h80; max_c = 8'h7b; nan_c = 8'h7f;
      end
      default: begin
        max_bits = 32'h40C0_0000; emin_b = 8'd127; mb = 2'd1;
        sb_c = 8'h08; max_c = 8'h07; nan_c = 8'h07;
      end
    endcase

    if (ex < emin_b) begin
      d   = emin_b - ex;
      efw = 8'd0;
    end else begin
      d   = 8'd0;
      efw = ex - emin_b;
    end
    shw     = 9'd23 - {7'd0, mb} + {1'b0, d};
    sh1_nxt = (shw > 9'd31) ? 5'd31 : shw[4:0];

    if (value_in[31] || a == 31'd0) begin
      e8 = 8'h00;
    end else if (a > 31'h7F00_0000) begin
      e8 = 8'hfe;
    end else if (ex == 8'd0) begin
      e8 = {7'd0, value_in[22] & value_in[21] & (|value_in[20:0])};
    end else begin
      e8 = ex + {7'd0, value_in[22] & ((|value_in[21:0]) | ex[0])};
    end

    spec1_nxt = 1'b1;
    if (a > 31'h7F80_0000) begin
      code1_nxt = (fmt_r == FMT_E8M0) ? 8'hff : nan_c;
    end else if (fmt_r == FMT_E8M0) begin
      code1_nxt = e8;
    end else if (a == 31'd0 || ex == 8'd0) begin
      code1_nxt = value_in[31] ? sb_c : 8'd0;
    end else if ({1'b0, a} > max_bits) begin
      code1_nxt = max_c | (value_in[31] ? sb_c : 8'd0);
    end else begin
      code1_nxt = 8'd0;
      spec1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_E4M3;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1_r <= in_tuser;
      fmt1_r  <= fmt_r;
      spec1_r <= spec1_nxt;
      code1_r <= code1_nxt;
      sig1_r  <= {1'b1, value_in[22:0]};
      sh1_r   <= sh1_nxt;
      ef1_r   <= efw[4:0];
      sb1_r   <= value_in[31] ? sb_c : 8'd0;
      dec1_r  <= dec_value;
    end
  end

  always_comb begin
    sig32   = {8'd0, sig1_r};
    shifted = sig32 >> sh1_r;
    guard   = sig32[sh1_r - 5'd1];
    below   = (32'd1 << (sh1_r - 5'd1)) - 32'd1;
    sticky  = |(sig32 & below);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2_r <= mode1_r;
      fmt2_r  <= fmt1_r;
      spec2_r <= spec1_r;
      code2_r <= code1_r;
      n2_r    <= shifted[3:0];
      up2_r   <= guard && (sticky || shifted[0]);
      ef2_r   <= ef1_r;
      sb2_r   <= sb1_r;
      dec2_r  <= dec1_r;
    end
  end

  always_comb begin
    case (fmt2_r)
      FMT_E4M3: base = {ef2_r, 3'd0};
      FMT_E5M2: base = {1'b0, ef2_r, 2'd0};
      default:  base = {2'd0, ef2_r, 1'b0};
    endcase
    if (spec2_r) begin
      code3_nxt = code2_r;
    end else begin
      code3_nxt = (base + {4'd0, n2_r} + {7'd0, up2_r}) | sb2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      code3_r  <= mode2_r ? code3_nxt : 8'd0;
      value3_r <= mode2_r ? 32'd0 : dec2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {value3_r, code3_r};

endmodule

@@ src/lpfc_checker.sv @@
// ----------------------------------------------------------------------------
// Low precision float converter checker
// Port-level assertions on the converter, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "low_precision_float_converter_macros.svh"

module lpfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `LPFC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output changed")
  `LPFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `LPFC_ASSERT(a_one_field, out_tvalid && out_tdata[7:0] != 8'd0 |-> out_tdata[39:8] == 32'd0, "code and value both nonzero")
  `LPFC_ASSERT(a_no_backpressure, out_tready |-> in_tready, "input stalled while output drains")

endmodule

bind low_precision_float_converter lpfc_checker u_lpfc_checker (.*);
